// ----- rtl/wvaa_pkg.sv -----
// ----------------------------------------------------------------------------
// wvaa_pkg: shared types and constants for the wind vector area adjust block
// Stage count, register indexes, adjust codes, fixed-point constants, the
// CORDIC arctangent table and the structs passed between modules.
// ----------------------------------------------------------------------------
package wvaa_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int N_STAGES = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

    // configuration register indexes
    localparam logic [2:0] CFG_LAT_MIN  = 3'd0;
    localparam logic [2:0] CFG_LAT_MAX  = 3'd1;
    localparam logic [2:0] CFG_LON_MIN  = 3'd2;
    localparam logic [2:0] CFG_LON_MAX  = 3'd3;
    localparam logic [2:0] CFG_KIND     = 3'd4;
    localparam logic [2:0] CFG_RELATIVE = 3'd5;
    localparam logic [2:0] CFG_AMOUNT   = 3'd6;

    // adjust kinds
    localparam logic [1:0] KIND_ANGLE   = 2'd0;
    localparam logic [1:0] KIND_KNOTS   = 2'd1;
    localparam logic [1:0] KIND_PERCENT = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam logic [29:0] INV_GAIN     = 30'd652032874;   // 1/K in Q30
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [18:0] ANGLE_ABS_BASE = 19'sd69120;     // 270 deg, Q8
    localparam logic signed [35:0] KNOTS_ONE      = 36'sd2157736;   // 1 knot, Q22 m/s

    // reciprocals for constant division
    localparam logic [17:0] RCP45_A = 18'd186414;      // 2^23 / 45
    localparam logic [27:0] RCP45_B = 28'd190887436;   // 2^33 / 45
    localparam logic [26:0] RCP225  = 27'd76354975;    // 2^34 / 225
    localparam logic [21:0] RCP25   = 22'd2684355;     // 2^26 / 25

    typedef struct packed {
        logic signed [15:0] u;
        logic signed [15:0] v;
        logic               in_box;
        logic               err;
        logic               work;
        logic               zero;
    } t_side;

    typedef struct packed {
        logic [31:0]        turn_rel;
        logic [31:0]        turn_abs;
        logic signed [31:0] knots;
    } t_derived;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/wvaa_ifs.sv -----
// ----------------------------------------------------------------------------
// wvaa_ifs: request channels of the wind vector area adjust block
// Grid point input, adjusted point output and register write channel.
// ----------------------------------------------------------------------------
interface wvaa_pt_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] point_lat;
    logic signed [25:0] point_lon;
    logic signed [15:0] wind_east;
    logic signed [15:0] wind_north;

    modport source(output valid, point_lat, point_lon, wind_east, wind_north,
                   input ready);
    modport sink(input valid, point_lat, point_lon, wind_east, wind_north,
                 output ready);
endinterface

interface wvaa_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] east_out;
    logic signed [15:0] north_out;
    logic               inside_area;
    logic               mode_error;
    logic               clipped;

    modport source(output valid, east_out, north_out, inside_area, mode_error, clipped,
                   input ready);
    modport sink(input valid, east_out, north_out, inside_area, mode_error, clipped,
                 output ready);
endinterface

interface wvaa_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [25:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/wvaa_derive.sv -----
// ----------------------------------------------------------------------------
// wvaa_derive: amount conversion
// Turns the adjust amount into turn fractions and Q22 knots, five stages.
// ----------------------------------------------------------------------------
module wvaa_derive (
    input  logic                     i_clk,
    input  logic signed [17:0]       i_amount,
    output wvaa_pkg::t_derived       o_der
);
    import wvaa_pkg::*;

    logic [17:0] r_a_rel, r_a_abs;
    logic        r1_neg_rel, r1_neg_abs, r1_neg_k;
    logic [26:0] r_p;
    logic [12:0] r2_q_rel, r2_q_abs;
    logic [18:0] r2_q_k;
    logic [17:0] r2_a_rel, r2_a_abs;
    logic [26:0] r2_p;
    logic        r2_neg_rel, r2_neg_abs, r2_neg_k;
    logic [26:0] r3_num_rel, r3_num_abs;
    logic [19:0] r3_num_k;
    logic [12:0] r3_q_rel, r3_q_abs;
    logic [18:0] r3_q_k;
    logic        r3_neg_rel, r3_neg_abs, r3_neg_k;
    logic [20:0] r4_lo_rel, r4_lo_abs;
    logic [11:0] r4_lo_k;
    logic [12:0] r4_q_rel, r4_q_abs;
    logic [18:0] r4_q_k;
    logic        r4_neg_rel, r4_neg_abs, r4_neg_k;

    logic signed [18:0] n_d_rel, n_d_abs;
    logic [17:0]        n_mag;
    logic [35:0]        n_m_rel, n_m_abs;
    logic [53:0]        n_m_k;
    logic [17:0]        n_qx_rel, n_qx_abs;
    logic [26:0]        n_qx_k;
    logic [5:0]         n_rem_rel, n_rem_abs;
    logic [7:0]         n_rem_k;
    logic [54:0]        n_l_rel, n_l_abs;
    logic [46:0]        n_l_k;
    logic [33:0]        n_v_rel, n_v_abs;
    logic [30:0]        n_v_k;

    always_comb begin
        n_d_rel  = {i_amount[17], i_amount};
        n_d_abs  = ANGLE_ABS_BASE - n_d_rel;
        n_mag    = i_amount[17] ? 18'(-n_d_rel) : 18'(n_d_rel);
        n_m_rel  = r_a_rel * RCP45_A;
        n_m_abs  = r_a_abs * RCP45_A;
        n_m_k    = r_p * RCP225;
        n_qx_rel = 18'(r2_q_rel) * 18'd45;
        n_qx_abs = 18'(r2_q_abs) * 18'd45;
        n_qx_k   = 27'(r2_q_k) * 27'd225;
        n_rem_rel = 6'(r2_a_rel - n_qx_rel);
        n_rem_abs = 6'(r2_a_abs - n_qx_abs);
        n_rem_k   = 8'(r2_p - n_qx_k);
        n_l_rel  = r3_num_rel * RCP45_B;
        n_l_abs  = r3_num_abs * RCP45_B;
        n_l_k    = r3_num_k * RCP225;
        n_v_rel  = {r4_q_rel, 21'd0} + 34'(r4_lo_rel);
        n_v_abs  = {r4_q_abs, 21'd0} + 34'(r4_lo_abs);
        n_v_k    = {r4_q_k, 12'd0} + 31'(r4_lo_k);
    end

    always_ff @(posedge i_clk) begin
        // magnitudes and signs
        r_a_rel    <= n_mag;
        r_a_abs    <= n_d_abs[18] ? 18'(-n_d_abs) : 18'(n_d_abs);
        r1_neg_rel <= n_d_rel[18];
        r1_neg_abs <= n_d_abs[18];
        r1_neg_k   <= i_amount[17];
        r_p        <= 27'(n_mag) * 27'd463;
        // coarse quotients
        r2_q_rel   <= n_m_rel[35:23];
        r2_q_abs   <= n_m_abs[35:23];
        r2_q_k     <= n_m_k[52:34];
        r2_a_rel   <= r_a_rel;
        r2_a_abs   <= r_a_abs;
        r2_p       <= r_p;
        r2_neg_rel <= r1_neg_rel;
        r2_neg_abs <= r1_neg_abs;
        r2_neg_k   <= r1_neg_k;
        // remainders scaled up with rounding bias
        r3_num_rel <= {n_rem_rel, 21'd22};
        r3_num_abs <= {n_rem_abs, 21'd22};
        r3_num_k   <= {n_rem_k, 12'd112};
        r3_q_rel   <= r2_q_rel;
        r3_q_abs   <= r2_q_abs;
        r3_q_k     <= r2_q_k;
        r3_neg_rel <= r2_neg_rel;
        r3_neg_abs <= r2_neg_abs;
        r3_neg_k   <= r2_neg_k;
        // fraction parts
        r4_lo_rel  <= n_l_rel[53:33];
        r4_lo_abs  <= n_l_abs[53:33];
        r4_lo_k    <= n_l_k[45:34];
        r4_q_rel   <= r3_q_rel;
        r4_q_abs   <= r3_q_abs;
        r4_q_k     <= r3_q_k;
        r4_neg_rel <= r3_neg_rel;
        r4_neg_abs <= r3_neg_abs;
        r4_neg_k   <= r3_neg_k;
        // combine and apply sign
        o_der.turn_rel <= r4_neg_rel ? 32'(-n_v_rel) : n_v_rel[31:0];
        o_der.turn_abs <= r4_neg_abs ? 32'(-n_v_abs) : n_v_abs[31:0];
        o_der.knots    <= r4_neg_k ? -$signed({1'b0, n_v_k}) : $signed({1'b0, n_v_k});
    end

endmodule

// ----- rtl/wvaa_vec_cell.sv -----
// ----------------------------------------------------------------------------
// wvaa_vec_cell: one CORDIC vectoring stage
// Drives y toward zero and accumulates the angle in turns.
// ----------------------------------------------------------------------------
module wvaa_vec_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [4:0]         i_stage,
    input  logic               i_vld,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic [31:0]        i_z,
    input  wvaa_pkg::t_side    i_side,
    output logic               o_vld,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic [31:0]        o_z,
    output wvaa_pkg::t_side    o_side
);
    import wvaa_pkg::*;

    logic signed [31:0] n_x, n_y;
    logic [31:0]        n_z;

    always_comb begin
        if (!i_y[31]) begin
            n_x = i_x + (i_y >>> i_stage);
            n_y = i_y - (i_x >>> i_stage);
            n_z = i_z + atan_turn(i_stage);
        end else begin
            n_x = i_x - (i_y >>> i_stage);
            n_y = i_y + (i_x >>> i_stage);
            n_z = i_z - atan_turn(i_stage);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_z    <= n_z;
            o_side <= i_side;
        end
    end

endmodule

// ----- rtl/wvaa_rot_cell.sv -----
// ----------------------------------------------------------------------------
// wvaa_rot_cell: one CORDIC rotation stage
// Rotates (x,y) to drive the residual angle toward zero.
// ----------------------------------------------------------------------------
module wvaa_rot_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [4:0]         i_stage,
    input  logic               i_vld,
    input  logic signed [35:0] i_x,
    input  logic signed [35:0] i_y,
    input  logic signed [33:0] i_z,
    input  wvaa_pkg::t_side    i_side,
    output logic               o_vld,
    output logic signed [35:0] o_x,
    output logic signed [35:0] o_y,
    output logic signed [33:0] o_z,
    output wvaa_pkg::t_side    o_side
);
    import wvaa_pkg::*;

    logic signed [35:0] n_x, n_y;
    logic signed [33:0] n_z;
    logic signed [33:0] n_a;

    always_comb begin
        n_a = $signed({2'b00, atan_turn(i_stage)});
        if (!i_z[33]) begin
            n_x = i_x - (i_y >>> i_stage);
            n_y = i_y + (i_x >>> i_stage);
            n_z = i_z - n_a;
        end else begin
            n_x = i_x + (i_y >>> i_stage);
            n_y = i_y - (i_x >>> i_stage);
            n_z = i_z + n_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_z    <= n_z;
            o_side <= i_side;
        end
    end

endmodule

// ----- rtl/wvaa_adjust.sv -----
// ----------------------------------------------------------------------------
// wvaa_adjust: polar adjust section
// Gain-corrects the magnitude, applies the angle or speed change and sets up
// the start vector for rotation. Ten stages.
// ----------------------------------------------------------------------------
module wvaa_adjust (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [31:0] i_x,
    input  logic [31:0]        i_z,
    input  wvaa_pkg::t_side    i_side,
    input  wvaa_pkg::t_derived i_der,
    input  logic [1:0]         i_kind,
    input  logic               i_rel,
    input  logic signed [17:0] i_amount,
    output logic               o_vld,
    output logic signed [35:0] o_x,
    output logic signed [33:0] o_z,
    output wvaa_pkg::t_side    o_side
);
    import wvaa_pkg::*;

    logic [9:0]         r_vld;
    t_side              r_side [0:9];
    logic [31:0]        r_theta [0:6];
    logic [30:0]        r_r [2:7];
    logic [60:0]        r1_prod;
    logic signed [49:0] r3_prod;
    logic [21:0]        r4_s_hi, r5_s_hi;
    logic [15:0]        r4_s_lo, r5_s_lo;
    logic               r4_neg, r5_neg, r6_neg, r7_neg;
    logic [17:0]        r5_q1, r6_q1, r7_q1;
    logic [20:0]        r6_t;
    logic [15:0]        r7_q2;
    logic [33:0]        r8_nr;
    logic [31:0]        r8_phi, r9_phi;
    logic [46:0]        r9_ph, r9_pl;

    logic [60:0]        n_rsum;
    logic [48:0]        n_mag;
    logic [49:0]        n_ssum;
    logic [43:0]        n_q1p;
    logic [4:0]         n_rem;
    logic [42:0]        n_q2p;
    logic signed [35:0] n_delta, n_rs, n_kn, n_nr;
    logic [31:0]        n_phi;
    logic [63:0]        n_xsum;
    logic [31:0]        n_quad;

    always_comb begin
        n_rsum  = r1_prod + 61'(1 << 29);
        n_mag   = r3_prod[49] ? 49'(-r3_prod) : 49'(r3_prod);
        n_ssum  = 50'(n_mag) + 50'd12800;
        n_q1p   = r4_s_hi * RCP25;
        n_rem   = 5'(r5_s_hi - 22'(r5_q1) * 22'd25);
        n_q2p   = r6_t * RCP25;
        n_delta = r7_neg ? -$signed({2'b00, r7_q1, r7_q2}) : $signed({2'b00, r7_q1, r7_q2});
        n_rs    = $signed({5'd0, r_r[7]});
        n_kn    = 36'(i_der.knots);
        case (i_kind)
            KIND_ANGLE: begin
                n_nr  = n_rs;
                n_phi = i_rel ? r_theta[6] - i_der.turn_rel : i_der.turn_abs;
            end
            KIND_KNOTS: begin
                n_nr  = i_rel ? n_rs + n_kn : n_kn;
                n_phi = r_theta[6];
            end
            default: begin
                n_nr  = n_rs + n_delta;
                n_phi = r_theta[6];
            end
        endcase
        // non-positive speed falls back to one knot
        if (i_kind != KIND_ANGLE && n_nr <= 36'sd0) begin
            n_nr = KNOTS_ONE;
        end
        n_xsum = {r9_ph, 17'd0} + 64'(r9_pl) + 64'(1 << 29);
        n_quad = r9_phi + QUARTER_TURN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[8:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < 10; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_theta[0] <= i_side.zero ? 32'd0 : i_z;
            for (int k = 1; k < 7; k++) begin
                r_theta[k] <= r_theta[k-1];
            end
            for (int k = 3; k < 8; k++) begin
                r_r[k] <= r_r[k-1];
            end
            // magnitude with gain correction
            r1_prod <= i_x[30:0] * INV_GAIN;
            r_r[2]  <= r_side[0].zero ? 31'd0 : n_rsum[60:30];
            // percentage: r * amount / 25600, rounded half away
            r3_prod <= $signed({1'b0, r_r[2]}) * i_amount;
            r4_neg  <= r3_prod[49];
            r4_s_hi <= n_ssum[47:26];
            r4_s_lo <= n_ssum[25:10];
            r5_q1   <= n_q1p[43:26];
            r5_s_hi <= r4_s_hi;
            r5_s_lo <= r4_s_lo;
            r5_neg  <= r4_neg;
            r6_t    <= {n_rem, r5_s_lo};
            r6_q1   <= r5_q1;
            r6_neg  <= r5_neg;
            r7_q2   <= n_q2p[41:26];
            r7_q1   <= r6_q1;
            r7_neg  <= r6_neg;
            // select new speed and angle
            r8_nr   <= n_nr[33:0];
            r8_phi  <= n_phi;
            // start vector, split product
            r9_ph   <= r8_nr[33:17] * INV_GAIN;
            r9_pl   <= r8_nr[16:0] * INV_GAIN;
            r9_phi  <= r8_phi;
            // fold into the right half plane
            if (n_quad >= HALF_TURN) begin
                o_x <= -$signed({2'b00, n_xsum[63:30]});
                o_z <= 34'($signed(r9_phi + HALF_TURN));
            end else begin
                o_x <= $signed({2'b00, n_xsum[63:30]});
                o_z <= 34'($signed(r9_phi));
            end
        end
    end

    assign o_vld  = r_vld[9];
    assign o_side = r_side[9];

endmodule

// ----- rtl/wind_vector_area_adjust.sv -----
// ----------------------------------------------------------------------------
// wind_vector_area_adjust: area-limited wind vector adjust
// A point passes the entry register, vectoring row, adjust section, rotation row and output register.
// Throughput: one point per cycle; a point enters each cycle the pipeline advances.
// The pipeline stalls as a whole only when a result waits and the last stage is full.
// Reset: synchronous active low; clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module wind_vector_area_adjust (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wvaa_pt_if.sink     i_pt,
    wvaa_cfg_if.sink    i_cfg,
    wvaa_res_if.source  o_res
);
    import wvaa_pkg::*;

    // configuration registers
    logic signed [23:0] r_lat_min, r_lat_max;
    logic signed [25:0] r_lon_min, r_lon_max;
    logic [1:0]         r_kind;
    logic               r_rel;
    logic signed [17:0] r_amount;

    t_derived           w_der;

    // entry stage
    logic               r_in_vld;
    logic signed [31:0] r_in_x, r_in_y;
    logic [31:0]        r_in_z;
    t_side              r_in_side;

    // vectoring chain taps
    logic               w_vv [0:N_STAGES];
    logic signed [31:0] w_vx [0:N_STAGES];
    logic signed [31:0] w_vy [0:N_STAGES];
    logic [31:0]        w_vz [0:N_STAGES];
    t_side              w_vs [0:N_STAGES];

    // rotation chain taps
    logic               w_rv [0:N_STAGES];
    logic signed [35:0] w_rx [0:N_STAGES];
    logic signed [35:0] w_ry [0:N_STAGES];
    logic signed [33:0] w_rz [0:N_STAGES];
    t_side              w_rs [0:N_STAGES];

    // output register
    logic               r_out_vld;
    logic signed [15:0] r_east, r_north;
    logic               r_inside, r_err, r_clip;

    logic               w_en;
    logic               n_inside, n_work, n_err;
    logic signed [31:0] n_u, n_v;
    logic signed [35:0] n_qx, n_qy;
    logic signed [15:0] n_east, n_north;
    logic               n_clip;

    // advance whenever the last stage can hand off to the output register
    assign w_en        = !w_rv[N_STAGES] || !r_out_vld || o_res.ready;
    assign i_pt.ready  = w_en;
    assign i_cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_min <= -24'sd5898240;
            r_lat_max <= 24'sd5898240;
            r_lon_min <= -26'sd11796480;
            r_lon_max <= 26'sd23592960;
            r_kind    <= KIND_ANGLE;
            r_rel     <= 1'b1;
            r_amount  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LAT_MIN:  r_lat_min <= i_cfg.data[23:0];
                CFG_LAT_MAX:  r_lat_max <= i_cfg.data[23:0];
                CFG_LON_MIN:  r_lon_min <= i_cfg.data;
                CFG_LON_MAX:  r_lon_max <= i_cfg.data;
                CFG_KIND:     r_kind    <= i_cfg.data[1:0];
                CFG_RELATIVE: r_rel     <= i_cfg.data[0];
                CFG_AMOUNT:   r_amount  <= i_cfg.data[17:0];
                default: ;
            endcase
        end
    end

    // amount conversions settle through the derive pipeline after a write
    wvaa_derive u_derive (
        .i_clk    (i_clk),
        .i_amount (r_amount),
        .o_der    (w_der)
    );

    // box test and mode decode
    always_comb begin
        n_inside = i_pt.point_lat >= r_lat_min && i_pt.point_lat <= r_lat_max &&
                   i_pt.point_lon >= r_lon_min && i_pt.point_lon <= r_lon_max;
        n_err    = n_inside && r_kind == KIND_PERCENT && !r_rel;
        n_work   = n_inside && r_kind != KIND_NONE && !n_err;
        n_u      = 32'(i_pt.wind_east) <<< 14;
        n_v      = 32'(i_pt.wind_north) <<< 14;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= i_pt.valid;
        end
    end

    // move a left-half vector to the right half, starting at half a turn
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_side.u      <= i_pt.wind_east;
            r_in_side.v      <= i_pt.wind_north;
            r_in_side.in_box <= n_inside;
            r_in_side.err    <= n_err;
            r_in_side.work   <= n_work;
            r_in_side.zero   <= i_pt.wind_east == 16'sd0 && i_pt.wind_north == 16'sd0;
            if (i_pt.wind_east[15]) begin
                r_in_x <= -n_u;
                r_in_y <= -n_v;
                r_in_z <= HALF_TURN;
            end else begin
                r_in_x <= n_u;
                r_in_y <= n_v;
                r_in_z <= '0;
            end
        end
    end

    assign w_vv[0] = r_in_vld;
    assign w_vx[0] = r_in_x;
    assign w_vy[0] = r_in_y;
    assign w_vz[0] = r_in_z;
    assign w_vs[0] = r_in_side;

    // vectoring row: each cell takes one micro-rotation
    for (genvar g = 0; g < N_STAGES; g++) begin : g_vec
        wvaa_vec_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (5'(g)),
            .i_vld   (w_vv[g]),
            .i_x     (w_vx[g]),
            .i_y     (w_vy[g]),
            .i_z     (w_vz[g]),
            .i_side  (w_vs[g]),
            .o_vld   (w_vv[g+1]),
            .o_x     (w_vx[g+1]),
            .o_y     (w_vy[g+1]),
            .o_z     (w_vz[g+1]),
            .o_side  (w_vs[g+1])
        );
    end

    wvaa_adjust u_adjust (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (w_vv[N_STAGES]),
        .i_x      (w_vx[N_STAGES]),
        .i_z      (w_vz[N_STAGES]),
        .i_side   (w_vs[N_STAGES]),
        .i_der    (w_der),
        .i_kind   (r_kind),
        .i_rel    (r_rel),
        .i_amount (r_amount),
        .o_vld    (w_rv[0]),
        .o_x      (w_rx[0]),
        .o_z      (w_rz[0]),
        .o_side   (w_rs[0])
    );

    assign w_ry[0] = '0;

    // rotation row back to components
    for (genvar g = 0; g < N_STAGES; g++) begin : g_rot
        wvaa_rot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (5'(g)),
            .i_vld   (w_rv[g]),
            .i_x     (w_rx[g]),
            .i_y     (w_ry[g]),
            .i_z     (w_rz[g]),
            .i_side  (w_rs[g]),
            .o_vld   (w_rv[g+1]),
            .o_x     (w_rx[g+1]),
            .o_y     (w_ry[g+1]),
            .o_z     (w_rz[g+1]),
            .o_side  (w_rs[g+1])
        );
    end

    // round to Q8, clamp, or pass the input vector through
    always_comb begin
        n_qx    = (w_rx[N_STAGES] + 36'sd8192) >>> 14;
        n_qy    = (w_ry[N_STAGES] + 36'sd8192) >>> 14;
        n_clip  = 1'b0;
        n_east  = n_qx[15:0];
        n_north = n_qy[15:0];
        if (n_qx > 36'sd32767) begin
            n_east = 16'sd32767;
            n_clip = 1'b1;
        end else if (n_qx < -36'sd32767) begin
            n_east = -16'sd32767;
            n_clip = 1'b1;
        end
        if (n_qy > 36'sd32767) begin
            n_north = 16'sd32767;
            n_clip  = 1'b1;
        end else if (n_qy < -36'sd32767) begin
            n_north = -16'sd32767;
            n_clip  = 1'b1;
        end
        if (!w_rs[N_STAGES].work) begin
            n_east  = w_rs[N_STAGES].u;
            n_north = w_rs[N_STAGES].v;
            n_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en && w_rv[N_STAGES]) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_rv[N_STAGES]) begin
            r_east   <= n_east;
            r_north  <= n_north;
            r_inside <= w_rs[N_STAGES].in_box;
            r_err    <= w_rs[N_STAGES].err;
            r_clip   <= n_clip;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.east_out    = r_east;
    assign o_res.north_out   = r_north;
    assign o_res.inside_area = r_inside;
    assign o_res.mode_error  = r_err;
    assign o_res.clipped     = r_clip;

endmodule

// ----- rtl/wvaa_checker.sv -----
// ----------------------------------------------------------------------------
// wvaa_checker: port-level checks
// Watches the top-level channels and flags results that cannot occur.
// ----------------------------------------------------------------------------
module wvaa_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [15:0] i_east,
    input  logic signed [15:0] i_north,
    input  logic               i_inside,
    input  logic               i_err,
    input  logic               i_clip
);

    // hold a result until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    // an error only arises inside the box
    a_err_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_err |-> i_inside && !i_clip)
        else $error("mode error outside the box or with clipping");

    // points outside the box pass through untouched
    a_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_inside |-> !i_clip && !i_err)
        else $error("flags set on a point outside the box");

    // a clipped result sits on a rail
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_clip |-> i_east == 16'sd32767 || i_east == -16'sd32767 ||
                                  i_north == 16'sd32767 || i_north == -16'sd32767)
        else $error("clipped result not at a rail");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind wind_vector_area_adjust wvaa_checker u_wvaa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_east      (o_res.east_out),
    .i_north     (o_res.north_out),
    .i_inside    (o_res.inside_area),
    .i_err       (o_res.mode_error),
    .i_clip      (o_res.clipped)
);

// ----- bench/tb_wind_vector_area_adjust.sv -----
// ----------------------------------------------------------------------------
// tb_wind_vector_area_adjust: self-checking bench for the wind vector adjust
// Streams grid points through the block under a series of register settings,
// predicts each adjusted point in fixed point and checks every result request
// field by field, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_wind_vector_area_adjust;
    import wvaa_pkg::*;

    localparam int  LATENCY     = 2 * N_STAGES + 12;
    localparam int  CYCLE_LIMIT = 400000;
    localparam longint INV_Q30  = 64'd652032874;

    typedef struct {
        logic signed [23:0] lat;
        logic signed [25:0] lon;
        logic signed [15:0] east;
        logic signed [15:0] north;
    } t_point;

    typedef struct {
        logic signed [15:0] east;
        logic signed [15:0] north;
        logic               in_box;
        logic               err;
        logic               clip;
    } t_adjusted;

    logic i_clk;
    logic i_rst_n;

    wvaa_pt_if  pt_ch();
    wvaa_cfg_if cfg_ch();
    wvaa_res_if res_ch();

    wind_vector_area_adjust uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_res  (res_ch.source)
    );

    // local copy of the register file, updated on each accepted write
    longint box_lat_lo, box_lat_hi, box_lon_lo, box_lon_hi;
    logic [1:0] mode_kind;
    logic       mode_rel;
    longint     mode_amount;

    logic [31:0] arc_table [24];

    t_point    point_backlog[$];
    t_adjusted adjusted_due[$];

    int  fail_count = 0;
    int  cycle_count = 0;
    bit  pt_took = 0;
    bit  steady_flow = 0;    // phase without any idling
    bit  stall_req = 0;
    bit  stall_done = 0;
    int  send_gap = 0;
    int  recv_gap = 0;

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // fixed-point helpers
    // ------------------------------------------------------------------
    // round half away from zero; divisor positive
    function automatic longint round_div(longint n, longint d);
        if (n < 0) return -((-n + d / 2) / d);
        return (n + d / 2) / d;
    endfunction

    function automatic logic [31:0] deg_turn(longint d);
        longint q;
        q = round_div(d * 64'sd4294967296, 92160);
        return q[31:0];
    endfunction

    function automatic longint knots_speed(longint k);
        return round_div(k * 16384 * 463, 900);
    endfunction

    function automatic int rand_gap();
        int pick;
        pick = $urandom_range(99);
        if (steady_flow || pick < 60) return 0;
        if (pick < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 4);
    endfunction

    function automatic longint rnd(longint lo, longint hi);
        return lo + longint'($urandom_range(int'(hi - lo)));
    endfunction

    // vectoring: (u,v) into magnitude and turn fraction
    task automatic wind_polar(input longint u, input longint v,
                              output longint mag, output logic [31:0] ang);
        longint x, y, t;
        logic [31:0] z;
        x = u * 16384;
        y = v * 16384;
        z = '0;
        if (u == 0 && v == 0) begin
            mag = 0;
            ang = '0;
            return;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < N_STAGES; i++) begin
            t = x;
            if (y >= 0) begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                z = z + arc_table[i];
            end else begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                z = z - arc_table[i];
            end
        end
        mag = (x * INV_Q30 + (64'sd1 <<< 29)) >>> 30;
        ang = z;
    endtask

    function automatic longint clamp_component(longint v, inout logic clip);
        longint q;
        q = (v + 8192) >>> 14;
        if (q > 32767) begin
            clip = 1'b1;
            return 32767;
        end
        if (q < -32767) begin
            clip = 1'b1;
            return -32767;
        end
        return q;
    endfunction

    // rotation: magnitude and turn fraction back into saturated (u,v)
    task automatic wind_cartesian(input longint mag, input logic [31:0] phi,
                                  output longint u, output longint v, inout logic clip);
        longint x, y, z, t;
        logic [31:0] probe;
        x = (mag * INV_Q30 + (64'sd1 <<< 29)) >>> 30;
        y = 0;
        probe = phi + QUARTER_TURN;
        if (probe >= HALF_TURN) begin
            x = -x;
            phi = phi + HALF_TURN;
        end
        z = (phi < HALF_TURN) ? longint'(phi) : longint'(phi) - 64'sd4294967296;
        for (int i = 0; i < N_STAGES; i++) begin
            t = x;
            if (z >= 0) begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                z = z - longint'(arc_table[i]);
            end else begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                z = z + longint'(arc_table[i]);
            end
        end
        u = clamp_component(x, clip);
        v = clamp_component(y, clip);
    endtask

    task automatic predict_adjust(input t_point p, output t_adjusted a);
        longint u, v, eu, ev, mag, new_mag;
        logic [31:0] theta, phi;
        logic clip;
        bit work;
        u = p.east;
        v = p.north;
        eu = u;
        ev = v;
        clip = 1'b0;
        a.in_box = (p.lat >= box_lat_lo && p.lat <= box_lat_hi &&
                    p.lon >= box_lon_lo && p.lon <= box_lon_hi);
        a.err = 1'b0;
        work = a.in_box && mode_kind != KIND_NONE;
        // absolute percentage is not a valid request: flag and pass through
        if (work && mode_kind == KIND_PERCENT && !mode_rel) begin
            work = 0;
            a.err = 1'b1;
        end
        if (work) begin
            wind_polar(u, v, mag, theta);
            if (mode_kind == KIND_ANGLE) begin
                new_mag = mag;
                if (mode_rel) phi = theta - deg_turn(mode_amount);
                else          phi = deg_turn(270 * 256 - mode_amount);
            end else begin
                phi = theta;
                if (mode_kind == KIND_KNOTS)
                    new_mag = mode_rel ? mag + knots_speed(mode_amount)
                                       : knots_speed(mode_amount);
                else
                    new_mag = mag + round_div(mag * mode_amount, 25600);
                // floor the speed at one knot
                if (new_mag <= 0) new_mag = knots_speed(256);
            end
            wind_cartesian(new_mag, phi, eu, ev, clip);
        end
        a.east  = eu[15:0];
        a.north = ev[15:0];
        a.clip  = clip;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // register writes: only called while the block is idle
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input longint val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val[25:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_LAT_MIN:  box_lat_lo  = val;
            CFG_LAT_MAX:  box_lat_hi  = val;
            CFG_LON_MIN:  box_lon_lo  = val;
            CFG_LON_MAX:  box_lon_hi  = val;
            CFG_KIND:     mode_kind   = val[1:0];
            CFG_RELATIVE: mode_rel    = val[0];
            CFG_AMOUNT:   mode_amount = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_mode(input longint la, input longint lb, input longint oa,
                            input longint ob, input logic [1:0] kind, input logic rel,
                            input longint amt);
        write_reg(CFG_LAT_MIN, la);
        write_reg(CFG_LAT_MAX, lb);
        write_reg(CFG_LON_MIN, oa);
        write_reg(CFG_LON_MAX, ob);
        write_reg(CFG_KIND, kind);
        write_reg(CFG_RELATIVE, rel);
        write_reg(CFG_AMOUNT, amt);
    endtask

    task automatic queue_point(input longint la, input longint lo,
                               input longint e, input longint n);
        t_point p;
        p.lat   = la[23:0];
        p.lon   = lo[25:0];
        p.east  = e[15:0];
        p.north = n[15:0];
        point_backlog.push_back(p);
    endtask

    // random points, mostly inside the current box
    task automatic queue_random(input int count);
        longint la, lo, e, n;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 75 && box_lat_lo <= box_lat_hi
                && box_lon_lo <= box_lon_hi) begin
                la = rnd(box_lat_lo, box_lat_hi);
                lo = rnd(box_lon_lo, box_lon_hi);
            end else begin
                la = rnd(-5898240, 5898240);
                lo = rnd(-11796480, 23592960);
            end
            case ($urandom_range(7))
                0: begin e = 32767 * ($urandom_range(1) ? 1 : -1); n = rnd(-32767, 32767); end
                1: begin e = rnd(-8, 8); n = rnd(-8, 8); end
                default: begin e = rnd(-32767, 32767); n = rnd(-32767, 32767); end
            endcase
            queue_point(la, lo, e, n);
        end
    endtask

    // wait on settled values at the rising edge until nothing is pending
    task automatic drain();
        do @(posedge i_clk);
        while (point_backlog.size() != 0 || pt_ch.valid || adjusted_due.size() != 0);
        repeat (LATENCY + 16) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // point driver: advance from the backlog at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!pt_ch.valid || pt_took)) begin
            if (send_gap > 0 || point_backlog.size() == 0) begin
                if (send_gap > 0) send_gap <= send_gap - 1;
                pt_ch.valid <= 1'b0;
            end else begin
                t_point p;
                p = point_backlog.pop_front();
                pt_ch.point_lat  <= p.lat;
                pt_ch.point_lon  <= p.lon;
                pt_ch.wind_east  <= p.east;
                pt_ch.wind_north <= p.north;
                pt_ch.valid      <= 1'b1;
                send_gap         <= rand_gap();
            end
        end
    end

    // result ready: random gaps plus one long hold while points keep coming
    always @(negedge i_clk) begin
        if (stall_req && !stall_done) begin
            stall_done = 1;
            recv_gap = 400;
        end
        if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            res_ch.ready <= 1'b0;
        end else begin
            recv_gap = rand_gap();
            res_ch.ready <= (recv_gap == 0) || steady_flow;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on accepted points, check accepted results
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        pt_took <= pt_ch.valid && pt_ch.ready;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n && pt_ch.valid && pt_ch.ready) begin
            t_point p;
            t_adjusted a;
            p.lat   = pt_ch.point_lat;
            p.lon   = pt_ch.point_lon;
            p.east  = pt_ch.wind_east;
            p.north = pt_ch.wind_north;
            predict_adjust(p, a);
            adjusted_due.push_back(a);
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (adjusted_due.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                t_adjusted w;
                w = adjusted_due.pop_front();
                if (res_ch.east_out !== w.east)
                    report_mismatch("east_out", res_ch.east_out, w.east);
                if (res_ch.north_out !== w.north)
                    report_mismatch("north_out", res_ch.north_out, w.north);
                if (res_ch.inside_area !== w.in_box)
                    report_mismatch("inside_area", res_ch.inside_area, w.in_box);
                if (res_ch.mode_error !== w.err)
                    report_mismatch("mode_error", res_ch.mode_error, w.err);
                if (res_ch.clipped !== w.clip)
                    report_mismatch("clipped", res_ch.clipped, w.clip);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        longint a, b, c, d;
        arc_table = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        box_lat_lo = -5898240;  box_lat_hi = 5898240;
        box_lon_lo = -11796480; box_lon_hi = 23592960;
        mode_kind = KIND_ANGLE; mode_rel = 1'b1; mode_amount = 0;

        i_rst_n = 1'b0;
        pt_ch.valid = 1'b0;
        pt_ch.point_lat = '0;
        pt_ch.point_lon = '0;
        pt_ch.wind_east = '0;
        pt_ch.wind_north = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings, field extremes, zero vector, box edges
        queue_point(0, 0, 0, 0);
        queue_point(5898240, 23592960, 32767, 32767);
        queue_point(-5898240, -11796480, -32767, -32767);
        queue_point(0, 0, 32767, -32767);
        queue_point(0, 0, -32767, 32767);
        queue_point(0, 0, 0, -1);
        queue_point(0, 0, -1, 0);
        drain();

        // small box, edges inclusive; absolute angle at its extreme
        set_mode(-65536, 65536, -65536, 65536, KIND_ANGLE, 1'b0, -92160);
        queue_point(-65536, -65536, 1000, 2000);
        queue_point(65536, 65536, -1000, 2000);
        queue_point(-65537, 0, 1000, 2000);
        queue_point(0, 65537, 1000, 2000);
        queue_point(0, 0, 0, 0);
        drain();
        set_mode(-5898240, 5898240, -11796480, 23592960, KIND_ANGLE, 1'b1, 92160);
        queue_point(0, 0, 32767, 0);
        queue_point(0, 0, 0, 0);
        drain();
        // absolute knots at max: saturates; relative knots at min: one knot floor
        write_reg(CFG_KIND, KIND_KNOTS);
        write_reg(CFG_RELATIVE, 1'b0);
        queue_point(0, 0, 300, -400);
        queue_point(0, 0, 0, 0);
        drain();
        write_reg(CFG_RELATIVE, 1'b1);
        write_reg(CFG_AMOUNT, -92160);
        queue_point(0, 0, 300, -400);
        queue_point(0, 0, 0, 0);
        drain();
        // percentage offset, then the invalid absolute percentage, then kind 3
        write_reg(CFG_KIND, KIND_PERCENT);
        write_reg(CFG_AMOUNT, 92160);
        queue_point(0, 0, 20000, 20000);
        queue_point(0, 0, -300, 70);
        drain();
        write_reg(CFG_RELATIVE, 1'b0);
        queue_point(0, 0, 1234, -4321);
        drain();
        write_reg(CFG_KIND, KIND_NONE);
        queue_point(0, 0, 1234, -4321);
        drain();

        // random phases with random settings
        for (int ph = 0; ph < 10; ph++) begin
            a = rnd(-5898240, 5898240);
            b = rnd(-5898240, 5898240);
            c = rnd(-11796480, 23592960);
            d = rnd(-11796480, 23592960);
            if (ph % 4 == 0) begin
                a = -5898240; b = 5898240; c = -11796480; d = 23592960;
            end
            if (a > b && ph != 7) begin a = a ^ b; b = a ^ b; a = a ^ b; end
            if (c > d && ph != 7) begin c = c ^ d; d = c ^ d; c = c ^ d; end
            set_mode(a, b, c, d, 2'($urandom_range(3)), 1'($urandom_range(1)),
                     rnd(-92160, 92160));
            steady_flow = (ph == 3);
            queue_random(55);
            if (ph == 5) stall_req = 1;
            drain();
            steady_flow = 0;
        end

        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
